FILE: rtl/jdc_pkg.sv
package jdc_pkg;

	// Default widths of the input fields.
	localparam int unsigned WHOLE_DAY_BITS_DEF = 23;
	localparam int unsigned FRACTION_BITS_DEF  = 32;

	// Constants of the conversion, all as exact integers.
	localparam longint unsigned GREG_START     = 64'd2299160;
	localparam longint unsigned CENTURY_OFFSET = 64'd7468865;
	localparam longint unsigned CENTURY_DAYS   = 64'd146097;
	localparam longint unsigned EPOCH_SHIFT    = 64'd1524;
	localparam longint unsigned YEAR_OFFSET    = 64'd12210;
	localparam longint unsigned DAYS_100Y      = 64'd36525;
	localparam longint unsigned DAYS_4Y        = 64'd1461;
	localparam longint unsigned MONTH_NUM      = 64'd306001;
	localparam longint unsigned MONTH_DEN      = 64'd10000;
	localparam longint unsigned YEAR_BASE_JF   = 64'd4716;
	localparam longint unsigned YEAR_BASE_REST = 64'd4715;

	// Days left after the whole years are removed stay within 123 to 489.
	localparam int unsigned DAYS_LEFT_BITS = 9;

	// Advance strobes for the three stages of a constant divider.
	typedef struct packed {
		logic est;
		logic mul;
		logic fix;
	} jdc_adv_t;

	// Month index: how many whole months of 30.6001 days fit into the days left.
	function automatic logic [4:0] month_index(input logic [DAYS_LEFT_BITS-1:0] days_left);
		logic [4:0]  cnt;
		logic [63:0] scaled;
		cnt    = '0;
		scaled = 64'(days_left) * MONTH_DEN;
		for (int k = 1; k <= 16; k++) begin
			if (scaled >= 64'(k) * MONTH_NUM) begin
				cnt = cnt + 5'd1;
			end
		end
		return cnt;
	endfunction

	// Days that precede the start of the month with the given index, floor(30.6001 g).
	// Only indexes up to 16 can occur; the rest read as zero.
	function automatic logic [DAYS_LEFT_BITS-1:0] days_before(input logic [4:0] g);
		logic [DAYS_LEFT_BITS-1:0] days;
		unique case (g)
			5'd0: days = 9'd0;
			5'd1: days = 9'd30;
			5'd2: days = 9'd61;
			5'd3: days = 9'd91;
			5'd4: days = 9'd122;
			5'd5: days = 9'd153;
			5'd6: days = 9'd183;
			5'd7: days = 9'd214;
			5'd8: days = 9'd244;
			5'd9: days = 9'd275;
			5'd10: days = 9'd306;
			5'd11: days = 9'd336;
			5'd12: days = 9'd367;
			5'd13: days = 9'd397;
			5'd14: days = 9'd428;
			5'd15: days = 9'd459;
			5'd16: days = 9'd489;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

FILE: rtl/jdc_cdiv.sv
module jdc_cdiv #(
	parameter int unsigned     DIVIDEND_BITS = 31,
	parameter longint unsigned DIVISOR       = 146097,
	parameter int unsigned     QUOT_BITS     = 14
) (
	input  logic                     clk,
	input  jdc_pkg::jdc_adv_t        adv,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	output logic [QUOT_BITS-1:0]     quotient
);
	import jdc_pkg::*;

	// Reciprocal rounded down: the estimate is the quotient or one less.
	localparam longint unsigned RECIP = (64'd1 << DIVIDEND_BITS) / DIVISOR;
	localparam int unsigned RECIP_BITS = $clog2(RECIP + 1);
	localparam int unsigned PROD_BITS =
		DIVIDEND_BITS + ((RECIP_BITS > QUOT_BITS) ? RECIP_BITS : QUOT_BITS);
	localparam logic [RECIP_BITS-1:0]    RECIP_V = RECIP_BITS'(RECIP);
	localparam logic [DIVIDEND_BITS-1:0] DIV_V   = DIVIDEND_BITS'(DIVISOR);

	logic [PROD_BITS-1:0]     scaled;
	logic [QUOT_BITS-1:0]     est_s1, est_s2, quot_s3;
	logic [DIVIDEND_BITS-1:0] num_s1, num_s2, prod_s2, rem;

	assign scaled = PROD_BITS'(dividend) * PROD_BITS'(RECIP_V);
	assign rem    = num_s2 - prod_s2;

	always_ff @(posedge clk) begin
		if (adv.est) begin
			est_s1 <= scaled[DIVIDEND_BITS +: QUOT_BITS];
			num_s1 <= dividend;
		end
		if (adv.mul) begin
			est_s2  <= est_s1;
			num_s2  <= num_s1;
			prod_s2 <= DIVIDEND_BITS'(DIVIDEND_BITS'(est_s1) * DIV_V);
		end
		if (adv.fix) begin
			quot_s3 <= est_s2 + QUOT_BITS'(rem >= DIV_V);
		end
	end

	assign quotient = quot_s3;

endmodule

FILE: rtl/julian_day_to_calendar.sv
// Converts a Julian date, given as a whole day count and a binary fraction of a day, into a
// calendar date and a UTC time of day. Half a day is added first so that days begin at
// midnight; whole days above 2299160 follow the Gregorian calendar, earlier ones the Julian
// calendar. The block is a thirteen-stage pipeline that takes one request per clock while the
// output is not stalled. The depth comes from the two divisions by constants (146097 and 36525
// days), each done as a reciprocal estimate, a back-multiply and a one-step correction over
// three stages. A stall at the output fills empty stages first; the input is held off only
// when every stage holds a request. Years outside 16 bits wrap to their low 16 bits.
module julian_day_to_calendar
	#(
	parameter int unsigned WHOLE_DAY_BITS = jdc_pkg::WHOLE_DAY_BITS_DEF,
	parameter int unsigned FRACTION_BITS  = jdc_pkg::FRACTION_BITS_DEF,
	localparam int unsigned IN_W = ((WHOLE_DAY_BITS + FRACTION_BITS + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	// whole_days, day_fraction, zero padding (lowest bit first)
	input  logic [IN_W-1:0] s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	// year, month, day_of_month, hour, minute, second_fixed, zero padding (lowest bit first)
	output logic [63:0]     m_tdata
);
	import jdc_pkg::*;

	localparam int unsigned F = FRACTION_BITS;
	localparam int unsigned NUM_STAGES = 13;

	// Widths of the date path, derived from the largest whole day count.
	localparam int unsigned I_BITS  = WHOLE_DAY_BITS + 1;
	localparam int unsigned XA_BITS = WHOLE_DAY_BITS + 3;
	localparam longint unsigned A_MAX = ((64'd4 << WHOLE_DAY_BITS) - CENTURY_OFFSET) / CENTURY_DAYS;
	localparam int unsigned A_BITS = $clog2(A_MAX + 1);
	localparam longint unsigned C_MAX = (64'd1 << WHOLE_DAY_BITS) + 64'd1 + A_MAX + EPOCH_SHIFT;
	localparam int unsigned C_BITS = $clog2(C_MAX + 1);
	localparam longint unsigned Y_MAX = 64'd100 * C_MAX - YEAR_OFFSET;
	localparam int unsigned Y_BITS = $clog2(Y_MAX + 1);
	localparam longint unsigned D_MAX = Y_MAX / DAYS_100Y;
	localparam int unsigned D_BITS = $clog2(D_MAX + 1);
	localparam int unsigned D_EXT  = (D_BITS > 16) ? D_BITS : 16;
	localparam int unsigned PE_BITS = C_BITS + 2;
	localparam int unsigned X_BITS  = DAYS_LEFT_BITS;

	// Pipeline control: a stage may load when it is empty or when the stage after it loads.
	logic [1:NUM_STAGES]   vld_q;
	logic [1:NUM_STAGES]   vin;
	logic [1:NUM_STAGES+1] rdy;

	always_comb begin
		rdy[NUM_STAGES+1] = m_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			rdy[k] = rdy[k+1] || !vld_q[k];
		end
		vin[1] = s_tvalid;
		for (int k = 2; k <= NUM_STAGES; k++) begin
			vin[k] = vld_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k];
				end
			end
		end
	end

	assign s_tready = rdy[1];
	assign m_tvalid = vld_q[NUM_STAGES];

	// Stage 1: add half a day. The carry out of the fraction moves into the day count.
	logic [WHOLE_DAY_BITS-1:0] whole_days;
	logic [F-1:0]              day_fraction;
	logic [F:0]                half_sum;
	logic [I_BITS-1:0]         i_s1, i_s2, i_s3, i_s4;
	logic [F-1:0]              frac_s [1:10];

	assign whole_days   = s_tdata[WHOLE_DAY_BITS-1:0];
	assign day_fraction = s_tdata[WHOLE_DAY_BITS +: F];
	assign half_sum     = (F+1)'(day_fraction) + ((F+1)'(1) << (F - 1));

	// Stages 2 to 4: the count of skipped Gregorian leap days needs floor((4I - 7468865) / 146097).
	// The dividend is only meaningful on the Gregorian side and is ignored otherwise.
	logic [XA_BITS-1:0] xa;
	logic [A_BITS-1:0]  a_s4;
	logic               greg_s2, greg_s3, greg_s4;
	jdc_adv_t           adv_a, adv_d;

	assign xa    = XA_BITS'({i_s1, 2'b00}) - XA_BITS'(CENTURY_OFFSET);
	assign adv_a = '{est: rdy[2], mul: rdy[3], fix: rdy[4]};

	jdc_cdiv #(
		.DIVIDEND_BITS(XA_BITS),
		.DIVISOR      (CENTURY_DAYS),
		.QUOT_BITS    (A_BITS)
	) u_div_century (
		.clk     (clk),
		.adv     (adv_a),
		.dividend(xa),
		.quotient(a_s4)
	);

	// Stage 5: day count shifted to the March-based epoch of the scheme.
	logic [C_BITS-1:0] c_next, a_ext;
	logic [C_BITS-1:0] c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;

	always_comb begin
		a_ext  = C_BITS'(a_s4);
		c_next = C_BITS'(i_s4) + C_BITS'(EPOCH_SHIFT);
		if (greg_s4) begin
			c_next = c_next + a_ext - (a_ext >> 2) + C_BITS'(1);
		end
	end

	// Stage 6 prepares 100C - 12210; stages 7 to 9 divide it by 36525 to get the year count D.
	logic [Y_BITS-1:0] y_s6;
	logic [D_BITS-1:0] d_s9, d_s10, d_s11, d_s12;

	assign adv_d = '{est: rdy[7], mul: rdy[8], fix: rdy[9]};

	jdc_cdiv #(
		.DIVIDEND_BITS(Y_BITS),
		.DIVISOR      (DAYS_100Y),
		.QUOT_BITS    (D_BITS)
	) u_div_year (
		.clk     (clk),
		.adv     (adv_d),
		.dividend(y_s6),
		.quotient(d_s9)
	);

	// Stage 10: days in the whole years, floor(1461 D / 4). Stage 11: days left in the year.
	logic [PE_BITS-1:0] e_prod;
	logic [C_BITS-1:0]  e_s10;
	logic [X_BITS-1:0]  x_s11, x_s12;

	assign e_prod = PE_BITS'(d_s9) * PE_BITS'(DAYS_4Y);

	// Stage 12: month index G. Stage 13: day of month, month and year.
	logic [4:0]        g_s12;
	logic [3:0]        mon_next, mon_s13;
	logic [X_BITS-1:0] dom_wide;
	logic [4:0]        dom_s13;
	logic [D_EXT-1:0]  d_ext;
	logic [15:0]       yr_next, yr_s13;

	always_comb begin
		if (g_s12 <= 5'd13) begin
			mon_next = 4'(g_s12 - 5'd1);
		end else begin
			mon_next = 4'(g_s12 - 5'd13);
		end
		dom_wide = x_s12 - days_before(g_s12);
		d_ext    = D_EXT'(d_s12);
		if (mon_next >= 4'd3) begin
			yr_next = d_ext[15:0] - 16'(YEAR_BASE_JF);
		end else begin
			yr_next = d_ext[15:0] - 16'(YEAR_BASE_REST);
		end
	end

	// Time of day, worked on the delayed fraction in the last three stages.
	// hour = floor(24 f), minute = floor(60 r1), seconds = 60 r2, each r the fraction left over.
	logic [F+4:0] p24;
	logic [F+5:0] p60m, p60s;
	logic [4:0]   hr_s11, hr_s12, hr_s13;
	logic [F-1:0] r1_s11, r2_s12;
	logic [5:0]   mn_s12, mn_s13;
	logic [21:0]  sec_s13;

	assign p24  = (F+5)'({frac_s[10], 4'b0000}) + (F+5)'({frac_s[10], 3'b000});
	assign p60m = (F+6)'({r1_s11, 6'b000000}) - (F+6)'({r1_s11, 2'b00});
	assign p60s = (F+6)'({r2_s12, 6'b000000}) - (F+6)'({r2_s12, 2'b00});

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			i_s1      <= I_BITS'(whole_days) + I_BITS'(half_sum[F]);
			frac_s[1] <= half_sum[F-1:0];
		end
		for (int k = 2; k <= 10; k++) begin
			if (rdy[k]) begin
				frac_s[k] <= frac_s[k-1];
			end
		end
		if (rdy[2]) begin
			i_s2    <= i_s1;
			greg_s2 <= i_s1 > I_BITS'(GREG_START);
		end
		if (rdy[3]) begin
			i_s3    <= i_s2;
			greg_s3 <= greg_s2;
		end
		if (rdy[4]) begin
			i_s4    <= i_s3;
			greg_s4 <= greg_s3;
		end
		if (rdy[5]) begin
			c_s5 <= c_next;
		end
		if (rdy[6]) begin
			c_s6 <= c_s5;
			y_s6 <= Y_BITS'(c_s5) * Y_BITS'(100) - Y_BITS'(YEAR_OFFSET);
		end
		if (rdy[7]) begin
			c_s7 <= c_s6;
		end
		if (rdy[8]) begin
			c_s8 <= c_s7;
		end
		if (rdy[9]) begin
			c_s9 <= c_s8;
		end
		if (rdy[10]) begin
			c_s10 <= c_s9;
			d_s10 <= d_s9;
			e_s10 <= C_BITS'(e_prod >> 2);
		end
		if (rdy[11]) begin
			x_s11  <= X_BITS'(c_s10 - e_s10);
			d_s11  <= d_s10;
			hr_s11 <= p24[F+4:F];
			r1_s11 <= p24[F-1:0];
		end
		if (rdy[12]) begin
			x_s12  <= x_s11;
			d_s12  <= d_s11;
			g_s12  <= month_index(x_s11);
			hr_s12 <= hr_s11;
			mn_s12 <= p60m[F+5:F];
			r2_s12 <= p60m[F-1:0];
		end
		if (rdy[13]) begin
			mon_s13 <= mon_next;
			dom_s13 <= dom_wide[4:0];
			yr_s13  <= yr_next;
			hr_s13  <= hr_s12;
			mn_s13  <= mn_s12;
			sec_s13 <= p60s[F+5:F-16];
		end
	end

	assign m_tdata = {6'b000000, sec_s13, mn_s13, hr_s13, dom_s13, mon_s13, yr_s13};

	// Every delivered result has its month, day of month, hour, minute and second in range.
	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mon_s13 >= 4'd1) && (mon_s13 <= 4'd12) && (dom_s13 >= 5'd1) &&
		(hr_s13 <= 5'd23) && (mn_s13 <= 6'd59) && (sec_s13 < 22'd3932160))
		else $error("converted fields out of range");

	// The year split must leave between 123 and 489 days, or a divider has slipped.
	a_days_left: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[11] |-> (x_s11 >= 9'd123) && (x_s11 <= 9'd489))
		else $error("days left in year out of range");

	// The input is held off only when the pipeline is full and the output is stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&vld_q) && !m_tready)
		else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/julian_day_to_calendar_tb.sv
`timescale 1ns / 100ps

// Checks the Julian date to calendar converter against its own software model of the
// conversion. Every request that the block accepts is converted here as well, and the
// expected calendar date waits in a queue until the block delivers its result. The stream
// runs through several traffic patterns: back to back, with the sender idling, with the
// receiver stalling, with both, and with one long hold-off that fills the pipeline.
module julian_day_to_calendar_tb;

	import jdc_pkg::*;

	localparam int unsigned WD_BITS = WHOLE_DAY_BITS_DEF;
	localparam int unsigned FR_BITS = FRACTION_BITS_DEF;
	localparam int unsigned IN_W    = ((WD_BITS + FR_BITS + 7) / 8) * 8;

	// The pipeline is thirteen stages deep; the drain wait at the end is well beyond that.
	localparam int unsigned DRAIN_CYCLES = 40;
	// Largest whole day count that the input field can carry.
	localparam logic [WD_BITS-1:0] WD_MAX = '1;

	// One calendar result, in the order the fields sit in m_tdata from the highest bit down.
	typedef struct packed {
		logic [21:0] second_fixed;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day_of_month;
		logic [3:0]  month;
		logic [15:0] year;
	} calendar_t;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata  = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [63:0]     m_tdata;

	// Calendar dates predicted for requests that were accepted but not yet delivered.
	calendar_t pending_dates[$];

	// Traffic shaping, in percent of cycles, and the length of a forced output hold-off.
	int unsigned send_idle_pct  = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_cycles    = 0;

	int unsigned fail_count = 0;

	julian_day_to_calendar i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	// Converts one Julian date exactly as the scheme defines it. All the decimal constants
	// are held as integer ratios, so every division here is a floor of non-negative values.
	function automatic calendar_t convert_julian_date(input logic [WD_BITS-1:0] whole_days,
		input logic [FR_BITS-1:0] day_fraction);
		longint unsigned sum, i_day, f_day;
		longint unsigned a, b, c, d, e, g, dom, mon, yr;
		longint unsigned t, unit_h, unit_m, hr, mn;
		calendar_t       r;
		// Adding half a day moves the start of the day from noon to midnight.
		sum   = 64'(day_fraction) + (64'd1 << (FR_BITS - 1));
		i_day = 64'(whole_days) + (sum >> FR_BITS);
		f_day = sum & ((64'd1 << FR_BITS) - 64'd1);
		if (i_day > GREG_START) begin
			a = (64'd4 * i_day - CENTURY_OFFSET) / CENTURY_DAYS;
			b = i_day + 64'd1 + a - a / 64'd4;
		end else begin
			b = i_day;
		end
		c   = b + EPOCH_SHIFT;
		d   = (64'd100 * c - YEAR_OFFSET) / DAYS_100Y;
		e   = (DAYS_4Y * d) / 64'd4;
		g   = (MONTH_DEN * (c - e)) / MONTH_NUM;
		dom = c - e - (MONTH_NUM * g) / MONTH_DEN;
		mon = (g <= 64'd13) ? g - 64'd1 : g - 64'd13;
		// January and February belong to the year after the one the count started in.
		// The subtraction may wrap; only its low 16 bits are kept, as two's complement.
		yr  = (mon >= 64'd3) ? d - YEAR_BASE_JF : d - YEAR_BASE_REST;
		// Time of day in units of 2^-FR_BITS seconds, split by exact integer division.
		t      = f_day * 64'd86400;
		unit_h = 64'd3600 << FR_BITS;
		unit_m = 64'd60 << FR_BITS;
		hr     = t / unit_h;
		t      = t - hr * unit_h;
		mn     = t / unit_m;
		t      = t - mn * unit_m;
		r.year         = yr[15:0];
		r.month        = mon[3:0];
		r.day_of_month = dom[4:0];
		r.hour         = hr[4:0];
		r.minute       = mn[5:0];
		r.second_fixed = 22'(t >> (FR_BITS - 16));
		return r;
	endfunction

	// Offers one request and holds it until the block takes it. The task is entered at a
	// falling edge and returns at a falling edge with tvalid still high, so that a request
	// that follows at once keeps the bus busy without a gap.
	task automatic send_date(input logic [WD_BITS-1:0] whole_days,
		input logic [FR_BITS-1:0] day_fraction);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({day_fraction, whole_days});
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_dates.push_back(convert_julian_date(whole_days, day_fraction));
		@(negedge clk);
	endtask

	// Drops tvalid and waits until every accepted request has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_dates.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Random dates, weighted toward the places where the conversion changes its behavior:
	// the switch to the Gregorian calendar, the modern era, and both ends of the range.
	task automatic send_random_date();
		logic [WD_BITS-1:0] wd;
		logic [FR_BITS-1:0] fr;
		int unsigned        pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			wd = WD_BITS'($urandom);
		end else if (pick < 60) begin
			wd = WD_BITS'(GREG_START - 64'd400 + 64'($urandom_range(800)));
		end else if (pick < 80) begin
			wd = WD_BITS'($urandom_range(2488069, 2415020));
		end else if (pick < 90) begin
			wd = WD_BITS'($urandom_range(3000));
		end else begin
			wd = WD_MAX - WD_BITS'($urandom_range(3000));
		end
		pick = $urandom_range(99);
		if (pick < 50) begin
			fr = $urandom;
		end else if (pick < 75) begin
			// Close to half a day, where the date rolls over to the next day.
			fr = 32'h8000_0000 + 32'($urandom_range(2000)) - 32'd1000;
		end else if (pick < 88) begin
			fr = 32'($urandom_range(2000));
		end else begin
			fr = 32'hFFFF_FFFF - 32'($urandom_range(2000));
		end
		send_date(wd, fr);
	endtask

	task automatic send_random_dates(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			send_random_date();
		end
	endtask

	// Field extremes, the calendar switch, leap days and the rollover at midnight.
	task automatic test_directed_dates();
		send_date('0, 32'h0000_0000);
		send_date('0, 32'h7FFF_FFFF);
		send_date('0, 32'h8000_0000);
		send_date('0, 32'hFFFF_FFFF);
		send_date(WD_MAX, 32'h0000_0000);
		send_date(WD_MAX, 32'h7FFF_FFFF);
		send_date(WD_MAX, 32'h8000_0000);
		send_date(WD_MAX, 32'hFFFF_FFFF);
		// Last day of the Julian calendar, reached from both sides of midnight.
		send_date(23'd2299159, 32'h8000_0000);
		send_date(23'd2299160, 32'h0000_0000);
		// First day of the Gregorian calendar.
		send_date(23'd2299160, 32'h8000_0000);
		send_date(23'd2299161, 32'h0000_0000);
		// Noon and midnight of the first day of 2000, and the last moment of 1999.
		send_date(23'd2451545, 32'h0000_0000);
		send_date(23'd2451544, 32'h8000_0000);
		send_date(23'd2451544, 32'h7FFF_FFFF);
		// The leap day of 2000, a century year that is a leap year.
		send_date(23'd2451603, 32'h8000_0000);
		// The start of the twentieth century, a century year that is not a leap year.
		send_date(23'd2415020, 32'h0000_0000);
		send_date(23'd2415079, 32'h8000_0000);
		// Around the start of year zero in the Julian calendar.
		send_date(23'd1721057, 32'h8000_0000);
		send_date(23'd1721058, 32'h8000_0000);
		// Alternating bit patterns in both fields.
		send_date(23'h2A_AAAA, 32'h5555_5555);
		send_date(23'h55_5555, 32'hAAAA_AAAA);
		drain_results();
	endtask

	task automatic test_back_to_back();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		send_random_dates(100);
		drain_results();
	endtask

	task automatic test_sender_idle();
		send_idle_pct  = 64;
		sink_stall_pct = 0;
		send_random_dates(100);
		drain_results();
	endtask

	task automatic test_receiver_stall();
		send_idle_pct  = 0;
		sink_stall_pct = 64;
		send_random_dates(100);
		drain_results();
	endtask

	task automatic test_both_idle();
		send_idle_pct  = 24;
		sink_stall_pct = 24;
		send_random_dates(140);
		drain_results();
	endtask

	// The receiver holds off long enough that every stage fills up and the input stalls,
	// while the sender keeps offering requests.
	task automatic test_full_pipeline();
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		hold_cycles    = 60;
		send_random_dates(40);
		drain_results();
	endtask

	// Receiver side: a forced hold-off takes priority over the random stalls.
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			m_tready    <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Compares each delivered result with the oldest predicted date, field by field.
	always @(posedge clk) begin
		calendar_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(calendar_t)-1:0];
			if (pending_dates.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result: year %0d month %0d day %0d %0d:%0d sec %0d",
						$signed(got.year), got.month, got.day_of_month, got.hour, got.minute,
						got.second_fixed);
				end
			end else begin
				want = pending_dates.pop_front();
				if (got.year !== want.year || got.month !== want.month ||
					got.day_of_month !== want.day_of_month || got.hour !== want.hour ||
					got.minute !== want.minute || got.second_fixed !== want.second_fixed) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("mismatch: expected %0d-%0d-%0d %0d:%0d sec %0d, got %0d-%0d-%0d %0d:%0d sec %0d",
							$signed(want.year), want.month, want.day_of_month, want.hour,
							want.minute, want.second_fixed, $signed(got.year), got.month,
							got.day_of_month, got.hour, got.minute, got.second_fixed);
					end
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_dates();
		test_back_to_back();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_full_pipeline();
		// Everything has come back; give the pipeline time to show any stray result.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_dates.size() == 0) begin
			$display("julian_day_to_calendar_tb: PASS");
		end else begin
			$display("julian_day_to_calendar_tb: FAIL");
		end
		$finish;
	end

	// This limit lies far beyond the length of a healthy run.
	initial begin
		#400000;
		$display("julian_day_to_calendar_tb: FAIL");
		$finish;
	end

endmodule
